// ----- hw/rtl/sfp_pkg.sv -----
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types and codes for the sync frame parser with Fletcher-8 checksum.
// ----------------------------------------------------------------------------
`default_nettype none

package sfp_pkg;

  localparam int PhaseW  = 4;
  localparam int KindW   = 3;
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = 16;

  // Parser phases
  localparam logic [PhaseW-1:0] PH_IDLE    = 4'd0;
  localparam logic [PhaseW-1:0] PH_SYNC1   = 4'd1;
  localparam logic [PhaseW-1:0] PH_CLASS   = 4'd2;
  localparam logic [PhaseW-1:0] PH_ID      = 4'd3;
  localparam logic [PhaseW-1:0] PH_LENLO   = 4'd4;
  localparam logic [PhaseW-1:0] PH_LENHI   = 4'd5;
  localparam logic [PhaseW-1:0] PH_PAYLOAD = 4'd6;
  localparam logic [PhaseW-1:0] PH_CHKA    = 4'd7;
  localparam logic [PhaseW-1:0] PH_CHKB    = 4'd8;

  // Result kinds
  localparam logic [KindW-1:0] KIND_DATA  = 3'd0;
  localparam logic [KindW-1:0] KIND_GOOD  = 3'd1;
  localparam logic [KindW-1:0] KIND_BAD   = 3'd2;
  localparam logic [KindW-1:0] KIND_LONG  = 3'd3;
  localparam logic [KindW-1:0] KIND_ABORT = 3'd4;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LEN     = 2'd2;

  // Configuration reset values
  localparam logic [7:0]  SYNC_FIRST_RST  = 8'd181;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'd98;
  localparam logic [15:0] MAX_LEN_RST     = 16'd1024;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] max_len;
  } sfp_cfg_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [7:0]       data_byte;
    logic [15:0]      byte_index;
    logic [7:0]       frame_class;
    logic [7:0]       frame_id;
    logic [15:0]      frame_length;
  } sfp_result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sfp_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// sfp_cfg_regs
// Configuration registers: sync bytes and maximum payload length.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       wr_en,
  input  wire logic [sfp_pkg::CfgIdxW-1:0] wr_index,
  input  wire logic [sfp_pkg::CfgDatW-1:0] wr_data,
  output sfp_pkg::sfp_cfg_t               cfg
);
  import sfp_pkg::*;

  sfp_cfg_t cfg_r;
  sfp_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_SYNC_FIRST:  cfg_nxt.sync_first  = wr_data[7:0];
        CFG_SYNC_SECOND: cfg_nxt.sync_second = wr_data[7:0];
        CFG_MAX_LEN:     cfg_nxt.max_len     = wr_data;
        default:         cfg_nxt = cfg_r;  // drop writes beyond the list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first  <= SYNC_FIRST_RST;
      cfg_r.sync_second <= SYNC_SECOND_RST;
      cfg_r.max_len     <= MAX_LEN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- hw/rtl/sfp_core.sv -----
// ----------------------------------------------------------------------------
// sfp_core
// Frame state machine and running Fletcher-8 sums; one byte per cycle while advance is high.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire sfp_pkg::sfp_cfg_t cfg,
  input  wire logic          item_valid,
  input  wire logic [7:0]    item_byte,
  input  wire logic          advance,
  output logic               has_result,
  output sfp_pkg::sfp_result_t result
);
  import sfp_pkg::*;

  logic [PhaseW-1:0] phase_r,  phase_nxt;
  logic [7:0]        sum_a_r,  sum_a_nxt;
  logic [7:0]        sum_b_r,  sum_b_nxt;
  logic [7:0]        class_r,  class_nxt;
  logic [7:0]        id_r,     id_nxt;
  logic [15:0]       length_r, length_nxt;
  logic [15:0]       count_r,  count_nxt;

  logic [7:0]  add_a;
  logic [7:0]  add_b;
  logic [15:0] len_full;
  logic [15:0] count_inc;
  logic        in_frame;

  assign add_a     = sum_a_r + item_byte;
  assign add_b     = sum_b_r + add_a;
  assign len_full  = {item_byte, length_r[7:0]};
  assign count_inc = count_r + 16'd1;
  assign in_frame  = (phase_r >= PH_CLASS) && (phase_r <= PH_CHKB);

  always_comb begin
    phase_nxt  = phase_r;
    sum_a_nxt  = sum_a_r;
    sum_b_nxt  = sum_b_r;
    class_nxt  = class_r;
    id_nxt     = id_r;
    length_nxt = length_r;
    count_nxt  = count_r;
    has_result = 1'b0;
    result.kind       = KIND_DATA;
    result.data_byte  = 8'd0;
    result.byte_index = 16'd0;

    if (item_byte == cfg.sync_first) begin
      // restart the hunt; report a frame cut short
      phase_nxt   = PH_SYNC1;
      has_result  = in_frame;
      result.kind = KIND_ABORT;
    end else begin
      case (phase_r)
        PH_SYNC1: begin
          if (item_byte == cfg.sync_second) begin
            phase_nxt  = PH_CLASS;
            sum_a_nxt  = 8'd0;
            sum_b_nxt  = 8'd0;
            class_nxt  = 8'd0;
            id_nxt     = 8'd0;
            length_nxt = 16'd0;
            count_nxt  = 16'd0;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_CLASS: begin
          class_nxt = item_byte;
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          phase_nxt = PH_ID;
        end
        PH_ID: begin
          id_nxt    = item_byte;
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          phase_nxt = PH_LENLO;
        end
        PH_LENLO: begin
          length_nxt = {8'd0, item_byte};
          sum_a_nxt  = add_a;
          sum_b_nxt  = add_b;
          phase_nxt  = PH_LENHI;
        end
        PH_LENHI: begin
          length_nxt = len_full;
          sum_a_nxt  = add_a;
          sum_b_nxt  = add_b;
          count_nxt  = 16'd0;
          if (len_full > cfg.max_len) begin
            phase_nxt   = PH_IDLE;
            has_result  = 1'b1;
            result.kind = KIND_LONG;
          end else if (len_full == 16'd0) begin
            phase_nxt = PH_CHKA;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          count_nxt = count_inc;
          if (count_inc >= length_r) begin
            phase_nxt = PH_CHKA;
          end
          has_result        = 1'b1;
          result.kind       = KIND_DATA;
          result.data_byte  = item_byte;
          result.byte_index = count_r;
        end
        PH_CHKA: begin
          if (item_byte == sum_a_r) begin
            phase_nxt = PH_CHKB;
          end else begin
            phase_nxt   = PH_IDLE;
            has_result  = 1'b1;
            result.kind = KIND_BAD;
          end
        end
        PH_CHKB: begin
          phase_nxt   = PH_IDLE;
          has_result  = 1'b1;
          result.kind = (item_byte == sum_b_r) ? KIND_GOOD : KIND_BAD;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    // header fields as they stand after this byte
    result.frame_class  = class_nxt;
    result.frame_id     = id_nxt;
    result.frame_length = length_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      sum_a_r  <= 8'd0;
      sum_b_r  <= 8'd0;
      class_r  <= 8'd0;
      id_r     <= 8'd0;
      length_r <= 16'd0;
      count_r  <= 16'd0;
    end else if (item_valid && advance) begin
      phase_r  <= phase_nxt;
      sum_a_r  <= sum_a_nxt;
      sum_b_r  <= sum_b_nxt;
      class_r  <= class_nxt;
      id_r     <= id_nxt;
      length_r <= length_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sfp_out_reg.sv -----
// ----------------------------------------------------------------------------
// sfp_out_reg
// Result register on the output channel; holds while the receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_out_reg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load,
  input  wire sfp_pkg::sfp_result_t load_data,
  input  wire logic            out_stall,
  output logic                 free,
  output logic                 out_valid,
  output sfp_pkg::sfp_result_t out_data
);
  import sfp_pkg::*;

  logic        valid_r, valid_nxt;
  sfp_result_t data_r;

  // free to take a new result this cycle
  assign free      = !valid_r || !out_stall;
  assign valid_nxt = load || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

// ----- hw/rtl/sync_frame_parser_fletcher8.sv -----
// ----------------------------------------------------------------------------
// sync_frame_parser_fletcher8
// Sync-framed byte parser with Fletcher-8 checksum check and payload stream.
//
// Input channel: one received byte per transfer (in_valid / in_stall).
// Output channel: zero or one result per byte (out_valid / out_stall):
//   payload bytes with their index, then a final good / bad checksum /
//   too long / aborted-by-sync result, each tagged with class, id and length.
// Config channel: cfg_valid / cfg_ready, always ready; index 0 first sync
//   byte, 1 second sync byte, 2 maximum payload length. Write only when idle.
// Data path: a byte taken in sits in the input register; its result is
//   registered in the output register once that register is free, and
//   the result transfers from there while out_stall is low.
//   Throughput: one byte per cycle while no result waits on a stalled output,
//   set by the state update between the input and result registers.
// Stall: the output register holds its result while out_stall is high; the
//   input register keeps taking bytes that produce no result, and in_stall
//   rises only when a byte with a result waits behind a stalled one.
// Reset (rst_n low, synchronous): parser idle, sums and header cleared,
//   config back to defaults, both registers empty.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_frame_parser_fletcher8 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_result_kind,
  output logic [7:0]       out_data_byte,
  output logic [15:0]      out_byte_index,
  output logic [7:0]       out_frame_class,
  output logic [7:0]       out_frame_id,
  output logic [15:0]      out_frame_length,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import sfp_pkg::*;

  sfp_cfg_t    cfg;
  sfp_result_t core_result;
  sfp_result_t out_data;
  logic        core_has_result;
  logic        out_free;
  logic        advance;
  logic        in_accept;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;

  assign cfg_ready = 1'b1;

  sfp_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // a byte without a result may always move on
  assign advance   = out_free || !core_has_result;
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  assign s1_valid_nxt = in_accept || (s1_valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  sfp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (s1_valid_r),
    .item_byte  (s1_byte_r),
    .advance    (advance),
    .has_result (core_has_result),
    .result     (core_result)
  );

  sfp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_valid_r && core_has_result && out_free),
    .load_data (core_result),
    .out_stall (out_stall),
    .free      (out_free),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign out_result_kind  = out_data.kind;
  assign out_data_byte    = out_data.data_byte;
  assign out_byte_index   = out_data.byte_index;
  assign out_frame_class  = out_data.frame_class;
  assign out_frame_id     = out_data.frame_id;
  assign out_frame_length = out_data.frame_length;

endmodule

`default_nettype wire

// ----- tb/sync_frame_parser_fletcher8_tb.sv -----
// ----------------------------------------------------------------------------
// sync_frame_parser_fletcher8_tb
// Self-checking bench for the sync frame parser. A directed byte script
// covers the header, payload and checksum paths and every terminating
// condition. Random frames follow under several sync and length settings,
// most of them well formed, some corrupted or cut short, with noise between.
// A byte-level parser model in the bench predicts the unpinned results. Results
// are compared field by field, in order, under random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_frame_parser_fletcher8_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfp_pkg::*;

  // Index past the end of the register list; writes to it must be dropped
  localparam logic [CfgIdxW-1:0] CFG_SPARE_IDX = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_result_kind;
  logic [7:0]  out_data_byte;
  logic [15:0] out_byte_index;
  logic [7:0]  out_frame_class;
  logic [7:0]  out_frame_id;
  logic [15:0] out_frame_length;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'h0000;

  sync_frame_parser_fletcher8 dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_data_byte    (out_data_byte),
    .out_byte_index   (out_byte_index),
    .out_frame_class  (out_frame_class),
    .out_frame_id     (out_frame_id),
    .out_frame_length (out_frame_length),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("sync_frame_parser_fletcher8_tb: done, errors");
    $finish;
  end

  // Parser model state and its copy of the registers
  sfp_cfg_t          model_cfg = '{SYNC_FIRST_RST, SYNC_SECOND_RST, MAX_LEN_RST};
  logic [PhaseW-1:0] ph = PH_IDLE;
  logic [7:0]        sum_lo = 8'h00;
  logic [7:0]        sum_hi = 8'h00;
  logic [7:0]        hdr_class = 8'h00;
  logic [7:0]        hdr_id = 8'h00;
  logic [15:0]       hdr_len = 16'h0000;
  logic [15:0]       pay_count = 16'h0000;

  sfp_result_t frame_results[$];
  int          mismatch_count = 0;
  int          in_idle_pct = 0;
  int          out_idle_pct = 0;

  // Directed rows carry a typed-in result alongside the byte
  bit          byte_pinned = 1'b0;
  sfp_result_t byte_pin_res = '0;

  typedef struct {
    logic [7:0]  rx;
    bit          pinned;
    sfp_result_t res;
  } script_row_t;

  script_row_t script[$];

  function automatic void fletcher_step(inout logic [7:0] a, inout logic [7:0] s,
                                        input logic [7:0] b);
    a = a + b;
    s = s + a;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, output sfp_result_t res);
    bit emits;
    emits = 1'b0;
    res = '0;
    if (b == model_cfg.sync_first) begin
      emits = (ph >= PH_CLASS) && (ph <= PH_CHKB);
      res.kind = KIND_ABORT;
      ph = PH_SYNC1;
    end else begin
      case (ph)
        PH_SYNC1: begin
          if (b == model_cfg.sync_second) begin
            ph = PH_CLASS;
            sum_lo = 8'h00;
            sum_hi = 8'h00;
            hdr_class = 8'h00;
            hdr_id = 8'h00;
            hdr_len = 16'h0000;
            pay_count = 16'h0000;
          end else begin
            ph = PH_IDLE;
          end
        end
        PH_CLASS: begin
          hdr_class = b;
          fletcher_step(sum_lo, sum_hi, b);
          ph = PH_ID;
        end
        PH_ID: begin
          hdr_id = b;
          fletcher_step(sum_lo, sum_hi, b);
          ph = PH_LENLO;
        end
        PH_LENLO: begin
          hdr_len = {8'h00, b};
          fletcher_step(sum_lo, sum_hi, b);
          ph = PH_LENHI;
        end
        PH_LENHI: begin
          hdr_len[15:8] = b;
          fletcher_step(sum_lo, sum_hi, b);
          pay_count = 16'h0000;
          if (hdr_len > model_cfg.max_len) begin
            ph = PH_IDLE;
            emits = 1'b1;
            res.kind = KIND_LONG;
          end else begin
            ph = (hdr_len == 16'h0000) ? PH_CHKA : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          fletcher_step(sum_lo, sum_hi, b);
          emits = 1'b1;
          res.kind = KIND_DATA;
          res.data_byte = b;
          res.byte_index = pay_count;
          pay_count = pay_count + 16'd1;
          if (pay_count >= hdr_len) ph = PH_CHKA;
        end
        PH_CHKA: begin
          if (b == sum_lo) begin
            ph = PH_CHKB;
          end else begin
            ph = PH_IDLE;
            emits = 1'b1;
            res.kind = KIND_BAD;
          end
        end
        PH_CHKB: begin
          ph = PH_IDLE;
          emits = 1'b1;
          res.kind = (b == sum_hi) ? KIND_GOOD : KIND_BAD;
        end
        default: ph = PH_IDLE;
      endcase
    end
    res.frame_class = hdr_class;
    res.frame_id = hdr_id;
    res.frame_length = hdr_len;
    return emits;
  endfunction

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= 100)
        $display("%0t %s: expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  // Receiver side: random stall, drawn fresh every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < out_idle_pct);
  end

  always @(posedge clk) begin : monitor
    sfp_result_t want;
    sfp_result_t predicted;
    bit          has_result;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (frame_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 100)
            $display("%0t unexpected result: expected none, actual kind %0d",
                     $time, out_result_kind);
        end else begin
          want = frame_results.pop_front();
          check_field("result_kind", want.kind, out_result_kind);
          check_field("data_byte", want.data_byte, out_data_byte);
          check_field("byte_index", want.byte_index, out_byte_index);
          check_field("frame_class", want.frame_class, out_frame_class);
          check_field("frame_id", want.frame_id, out_frame_id);
          check_field("frame_length", want.frame_length, out_frame_length);
        end
      end
      if (in_valid && !in_stall) begin
        has_result = parse_byte(in_rx_byte, predicted);
        if (byte_pinned) frame_results.push_back(byte_pin_res);
        else if (has_result) frame_results.push_back(predicted);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit pin, input sfp_result_t res);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    byte_pinned <= pin;
    byte_pin_res <= res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold the input until every expected result is out and the pipe is empty
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frame_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SYNC_FIRST:  model_cfg.sync_first = val[7:0];
      CFG_SYNC_SECOND: model_cfg.sync_second = val[7:0];
      CFG_MAX_LEN:     model_cfg.max_len = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [7:0] sf, input logic [7:0] ss,
                               input logic [15:0] ml);
    drain_results();
    write_reg(CFG_SYNC_FIRST, {8'h00, sf});
    write_reg(CFG_SYNC_SECOND, {8'h00, ss});
    write_reg(CFG_MAX_LEN, ml);
  endtask

  function automatic void plain_row(input logic [7:0] rx);
    script_row_t r;
    r.rx = rx;
    r.pinned = 1'b0;
    r.res = '0;
    script.push_back(r);
  endfunction

  function automatic void closing_row(input logic [7:0] rx, input logic [KindW-1:0] kind,
                                      input logic [7:0] cls, input logic [7:0] fid,
                                      input logic [15:0] len);
    script_row_t r;
    r.rx = rx;
    r.pinned = 1'b1;
    r.res = '0;
    r.res.kind = kind;
    r.res.frame_class = cls;
    r.res.frame_id = fid;
    r.res.frame_length = len;
    script.push_back(r);
  endfunction

  // One frame with random content; some get a bad checksum, some are cut short
  task automatic send_random_frame(inout int sent);
    logic [7:0]  frame_bytes[$];
    logic [7:0]  ca;
    logic [7:0]  cb;
    logic [7:0]  bb;
    logic [15:0] len;
    int unsigned pick;
    int unsigned span;
    int unsigned cut;
    pick = $urandom_range(0, 99);
    if (pick < 10 && model_cfg.max_len != 16'hFFFF) begin
      span = 65534 - model_cfg.max_len;
      len = model_cfg.max_len + 16'd1 + 16'($urandom_range(0, span));
    end else if (pick < 13) begin
      len = 16'($urandom_range(13, 300));
    end else begin
      len = 16'($urandom_range(0, 12));
    end
    frame_bytes = {model_cfg.sync_first, model_cfg.sync_second,
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   len[7:0], len[15:8]};
    ca = 8'h00;
    cb = 8'h00;
    for (int i = 2; i < 6; i++) fletcher_step(ca, cb, frame_bytes[i]);
    if (len <= model_cfg.max_len) begin
      for (int i = 0; i < len; i++) begin
        bb = 8'($urandom_range(0, 255));
        if (bb == model_cfg.sync_first) bb = ~bb;
        frame_bytes.push_back(bb);
        fletcher_step(ca, cb, bb);
      end
    end
    pick = $urandom_range(0, 99);
    if (pick < 8) ca = ca ^ 8'($urandom_range(1, 255));
    else if (pick < 16) cb = cb ^ 8'($urandom_range(1, 255));
    frame_bytes.push_back(ca);
    frame_bytes.push_back(cb);
    if (pick >= 16 && pick < 26) begin
      cut = $urandom_range(1, frame_bytes.size() - 1);
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
      frame_bytes.push_back((pick < 22) ? model_cfg.sync_first : 8'($urandom_range(0, 255)));
    end
    foreach (frame_bytes[k]) send_byte(frame_bytes[k], 1'b0, '0);
    sent += frame_bytes.size();
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    logic [7:0]  sf;
    logic [7:0]  ss;
    logic [15:0] ml;
    int          target;
    int          sent;
    in_idle_pct = 30;
    out_idle_pct = 54;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Write past the register list; the defaults must survive it
    write_reg(CFG_SPARE_IDX, 16'hFFFF);

    // Missing second sync, then a frame aborted by sync in the id byte
    plain_row(SYNC_FIRST_RST);
    plain_row(8'h13);
    plain_row(SYNC_FIRST_RST);
    plain_row(SYNC_SECOND_RST);
    plain_row(8'hAA);
    closing_row(SYNC_FIRST_RST, KIND_ABORT, 8'hAA, 8'h00, 16'h0000);
    // Good frame, extreme header and payload bytes, checksum 00 00
    plain_row(SYNC_SECOND_RST);
    plain_row(8'hFF);
    plain_row(8'h00);
    plain_row(8'h02);
    plain_row(8'h00);
    plain_row(8'hFF);
    plain_row(8'h00);
    plain_row(8'h00);
    closing_row(8'h00, KIND_GOOD, 8'hFF, 8'h00, 16'h0002);
    // Zero-length frame straight to a wrong first checksum byte
    plain_row(SYNC_FIRST_RST);
    plain_row(SYNC_SECOND_RST);
    plain_row(8'h01);
    plain_row(8'h02);
    plain_row(8'h00);
    plain_row(8'h00);
    closing_row(8'h04, KIND_BAD, 8'h01, 8'h02, 16'h0000);
    // Declared length one past the limit
    plain_row(SYNC_FIRST_RST);
    plain_row(SYNC_SECOND_RST);
    plain_row(8'h07);
    plain_row(8'h08);
    plain_row(8'h01);
    closing_row(8'h04, KIND_LONG, 8'h07, 8'h08, 16'h0401);

    foreach (script[i]) send_byte(script[i].rx, script[i].pinned, script[i].res);

    for (int seg = 0; seg < 7; seg++) begin
      target = 270;
      sf = 8'($urandom_range(0, 255));
      ss = sf ^ 8'($urandom_range(1, 255));
      case (seg)
        0: begin
          sf = 8'hFF;
          ss = 8'h00;
          ml = 16'd0;
        end
        1: begin
          sf = 8'h00;
          ss = 8'hFF;
          ml = 16'hFFFF;
          target = 120;
        end
        2: ml = 16'($urandom_range(0, 16));
        3: begin
          // equal sync bytes: the first-sync rule wins, no frame ever starts
          ss = sf;
          ml = 16'd8;
          target = 100;
        end
        4: ml = 16'd4;
        5: begin
          sf = SYNC_FIRST_RST;
          ss = SYNC_SECOND_RST;
          ml = MAX_LEN_RST;
        end
        default: ml = 16'($urandom_range(0, 300));
      endcase
      apply_setting(sf, ss, ml);
      if (seg < 2) begin
        in_idle_pct = 30;
        out_idle_pct = 54;
      end else if (seg < 4) begin
        in_idle_pct = 54;
        out_idle_pct = 30;
      end else begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      sent = 0;
      while (sent < target) send_random_frame(sent);
    end

    drain_results();
    if (mismatch_count == 0 && frame_results.size() == 0) begin
      $display("sync_frame_parser_fletcher8_tb: done, clean");
    end else begin
      $display("sync_frame_parser_fletcher8_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
